// ----- rtl/mfs_pkg.sv -----
// Shared types, constants and codes for the maximum-frequency stack.
`timescale 1ns / 1ps
package mfs_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int DISTINCT_KEYS = 16;
    localparam int CAPACITY      = 64;

    localparam int KEY_W   = $clog2(DISTINCT_KEYS);
    localparam int SLOT_AW = $clog2(CAPACITY);
    localparam int PTR_W   = $clog2(CAPACITY + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [SLOT_AW-1:0]    slot_addr_t;
    typedef logic [KEY_W-1:0]      key_idx_t;

    localparam ptr_t NIL_SLOT = PTR_W'(CAPACITY);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_PUSH,
        ST_POP_HEAD,
        ST_POP_SLOT
    } state_t;

    typedef struct packed {
        logic               command;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        status_t            status;
        logic [6:0]         top_level;
    } out_word_t;

    typedef struct packed {
        value_t value;
        ptr_t   below;
    } slot_entry_t;

    typedef struct packed {
        logic        lh_rd_en;
        slot_addr_t  lh_rd_addr;
        logic        lh_wr_en;
        slot_addr_t  lh_wr_addr;
        ptr_t        lh_wr_data;
        logic        fl_rd_en;
        slot_addr_t  fl_rd_addr;
        logic        fl_wr_en;
        slot_addr_t  fl_wr_addr;
        ptr_t        fl_wr_data;
        logic        sl_rd_en;
        slot_addr_t  sl_rd_addr;
        logic        sl_wr_en;
        slot_addr_t  sl_wr_addr;
        slot_entry_t sl_wr_data;
    } store_req_t;

    typedef struct packed {
        ptr_t        lh_data;
        ptr_t        fl_data;
        slot_entry_t sl_data;
    } store_rsp_t;

    typedef struct packed {
        logic     en;
        key_idx_t idx;
        value_t   value;
        ptr_t     count;
    } key_wr_t;

    typedef struct packed {
        logic     hit;
        key_idx_t hit_idx;
        ptr_t     hit_count;
        logic     free_found;
        key_idx_t free_idx;
    } key_rsp_t;

endpackage

// ----- rtl/max_frequency_stack_unit.sv -----
// Top level: sequencer of the maximum-frequency stack with output register.
//
//  channel | dir | ports                      | word
//  s_      | in  | s_valid s_ready s_data     | in_word_t  (command, value)
//  m_      | out | m_valid m_ready m_data     | out_word_t (popped_value, status, top_level)
//
//  Reads are registered. A push steps through ST_LOOK and ST_PUSH (level head and free
//  chain read together), a pop through ST_LOOK, ST_POP_HEAD and ST_POP_SLOT (level
//  head, then slot). A full push answers in ST_LOOK, an empty pop in ST_LOOK or ST_POP_HEAD.
//  Reset is synchronous on aresetn; memories need no clearing pass.
//  A waiting result holds the last step of the next item until m_ready frees it.
`timescale 1ns / 1ps
module max_frequency_stack_unit
    import mfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    state_t    state_reg, state_next;
    logic      cmd_reg;
    value_t    val_reg;
    ptr_t      free_head_reg, free_head_next;
    ptr_t      max_level_reg, max_level_next;
    key_idx_t  k_reg, k_next;
    ptr_t      lvl_reg, lvl_next;
    ptr_t      slot_reg, slot_next;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    store_req_t req;
    store_rsp_t rsp;
    key_wr_t    kwr;
    key_rsp_t   krsp;
    value_t     search_value;

    logic              out_free;
    logic              push_ok;
    logic [PTR_W:0]    cnt_inc;
    ptr_t              push_lvl;

    mfs_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    mfs_keys u_keys (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .search_value (search_value),
        .wr           (kwr),
        .rsp          (krsp)
    );

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign search_value = (state_reg == ST_POP_SLOT) ? rsp.sl_data.value : val_reg;

    assign push_ok  = (krsp.hit || krsp.free_found) && (free_head_reg != NIL_SLOT);
    assign cnt_inc  = {1'b0, (krsp.hit ? krsp.hit_count : ptr_t'(0))} + (PTR_W + 1)'(1);
    assign push_lvl = (cnt_inc > (PTR_W + 1)'(CAPACITY)) ? PTR_W'(CAPACITY)
                                                         : cnt_inc[PTR_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if (cmd_reg == CMD_PUSH) begin
                    if (push_ok) state_next = ST_PUSH;
                    else if (out_free) state_next = ST_IDLE;
                end else begin
                    if (max_level_reg != '0 && max_level_reg <= PTR_W'(CAPACITY))
                        state_next = ST_POP_HEAD;
                    else if (out_free) state_next = ST_IDLE;
                end
            end
            ST_PUSH: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_POP_HEAD: begin
                if (rsp.lh_data < NIL_SLOT) state_next = ST_POP_SLOT;
                else if (out_free) state_next = ST_IDLE;
            end
            ST_POP_SLOT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        req            = '0;
        kwr            = '0;
        free_head_next = free_head_reg;
        max_level_next = max_level_reg;
        k_next         = k_reg;
        lvl_next       = lvl_reg;
        slot_next      = slot_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        unique case (state_reg)
            ST_IDLE: ;
            ST_LOOK: begin
                if (cmd_reg == CMD_PUSH) begin
                    if (push_ok) begin
                        k_next          = krsp.hit ? krsp.hit_idx : krsp.free_idx;
                        lvl_next        = push_lvl;
                        slot_next       = free_head_reg;
                        req.fl_rd_en    = 1'b1;
                        req.fl_rd_addr  = free_head_reg[SLOT_AW-1:0];
                        req.lh_rd_en    = 1'b1;
                        req.lh_rd_addr  = SLOT_AW'(push_lvl - PTR_W'(1));
                    end else if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{popped_value: '0, status: STATUS_FULL,
                                         top_level: 7'(max_level_reg)};
                    end
                end else begin
                    if (max_level_reg != '0 && max_level_reg <= PTR_W'(CAPACITY)) begin
                        req.lh_rd_en   = 1'b1;
                        req.lh_rd_addr = SLOT_AW'(max_level_reg - PTR_W'(1));
                    end else if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{popped_value: '0, status: STATUS_EMPTY,
                                         top_level: 7'(max_level_reg)};
                    end
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    req.sl_wr_en   = 1'b1;
                    req.sl_wr_addr = slot_reg[SLOT_AW-1:0];
                    req.sl_wr_data = '{value: val_reg, below: rsp.lh_data};
                    req.lh_wr_en   = 1'b1;
                    req.lh_wr_addr = SLOT_AW'(lvl_reg - PTR_W'(1));
                    req.lh_wr_data = slot_reg;
                    kwr            = '{en: 1'b1, idx: k_reg, value: val_reg, count: lvl_reg};
                    free_head_next = rsp.fl_data;
                    if (lvl_reg > max_level_reg) max_level_next = lvl_reg;
                    m_valid_next   = 1'b1;
                    m_data_next    = '{popped_value: '0, status: STATUS_DONE,
                                       top_level: 7'(max_level_next)};
                end
            end
            ST_POP_HEAD: begin
                slot_next = rsp.lh_data;
                if (rsp.lh_data < NIL_SLOT) begin
                    req.sl_rd_en   = 1'b1;
                    req.sl_rd_addr = rsp.lh_data[SLOT_AW-1:0];
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{popped_value: '0, status: STATUS_EMPTY,
                                     top_level: 7'(max_level_reg)};
                end
            end
            ST_POP_SLOT: begin
                if (out_free) begin
                    req.lh_wr_en   = 1'b1;
                    req.lh_wr_addr = SLOT_AW'(max_level_reg - PTR_W'(1));
                    req.lh_wr_data = rsp.sl_data.below;
                    req.fl_wr_en   = 1'b1;
                    req.fl_wr_addr = slot_reg[SLOT_AW-1:0];
                    req.fl_wr_data = free_head_reg;
                    free_head_next = slot_reg;
                    if (krsp.hit) begin
                        kwr = '{en: 1'b1, idx: krsp.hit_idx, value: rsp.sl_data.value,
                                count: krsp.hit_count - PTR_W'(1)};
                    end
                    if (rsp.sl_data.below >= NIL_SLOT)
                        max_level_next = max_level_reg - PTR_W'(1);
                    m_valid_next   = 1'b1;
                    m_data_next    = '{popped_value: 32'(rsp.sl_data.value),
                                       status: STATUS_DONE,
                                       top_level: 7'(max_level_next)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            max_level_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            max_level_reg <= max_level_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_data.command;
            val_reg <= VALUE_BITS'(s_data.value);
        end
        k_reg      <= k_next;
        lvl_reg    <= lvl_next;
        slot_reg   <= slot_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        max_level_reg <= PTR_W'(CAPACITY))
        else $error("top level beyond capacity");

    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LOOK))
        else $error("accepted word not looked up");

    a_push_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) |-> (slot_reg != NIL_SLOT && lvl_reg != '0))
        else $error("push commits without a free slot");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_DONE) |-> (m_data.popped_value == '0))
        else $error("failed step carries a value");
`endif

endmodule

// ----- rtl/mfs_keys.sv -----
// Key table: distinct values with their counts and a parallel search.
`timescale 1ns / 1ps
module mfs_keys
    import mfs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  value_t   search_value,
    input  key_wr_t  wr,
    output key_rsp_t rsp
);

    value_t key_value_reg [DISTINCT_KEYS];
    ptr_t   key_count_reg [DISTINCT_KEYS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DISTINCT_KEYS; i++) begin
                key_count_reg[i] <= '0;
            end
        end else if (wr.en) begin
            key_count_reg[wr.idx] <= wr.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            key_value_reg[wr.idx] <= wr.value;
        end
    end

    always_comb begin
        rsp = '0;
        for (int i = DISTINCT_KEYS - 1; i >= 0; i--) begin
            if (key_count_reg[i] != '0 && key_value_reg[i] == search_value) begin
                rsp.hit       = 1'b1;
                rsp.hit_idx   = KEY_W'(i);
                rsp.hit_count = key_count_reg[i];
            end
            if (key_count_reg[i] == '0) begin
                rsp.free_found = 1'b1;
                rsp.free_idx   = KEY_W'(i);
            end
        end
    end

endmodule

// ----- rtl/mfs_store.sv -----
// Slot store, level heads and free chain, each a memory with registered read.
`timescale 1ns / 1ps
module mfs_store
    import mfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  store_req_t req,
    output store_rsp_t rsp
);

    ptr_t        lh_mem [CAPACITY];
    ptr_t        fl_mem [CAPACITY];
    slot_entry_t sl_mem [CAPACITY];
    logic [CAPACITY-1:0] lh_vld_reg;
    logic [CAPACITY-1:0] fl_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lh_vld_reg <= '0;
            fl_vld_reg <= '0;
        end else begin
            if (req.lh_wr_en) begin
                lh_vld_reg[req.lh_wr_addr] <= 1'b1;
            end
            if (req.fl_wr_en) begin
                fl_vld_reg[req.fl_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.lh_wr_en) begin
            lh_mem[req.lh_wr_addr] <= req.lh_wr_data;
        end
        if (req.fl_wr_en) begin
            fl_mem[req.fl_wr_addr] <= req.fl_wr_data;
        end
        if (req.sl_wr_en) begin
            sl_mem[req.sl_wr_addr] <= req.sl_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.lh_rd_en) begin
            rsp.lh_data <= lh_vld_reg[req.lh_rd_addr] ? lh_mem[req.lh_rd_addr] : NIL_SLOT;
        end
        if (req.fl_rd_en) begin
            rsp.fl_data <= fl_vld_reg[req.fl_rd_addr] ? fl_mem[req.fl_rd_addr]
                                                      : PTR_W'(req.fl_rd_addr) + PTR_W'(1);
        end
        if (req.sl_rd_en) begin
            rsp.sl_data <= sl_mem[req.sl_rd_addr];
        end
    end

endmodule

// ----- bench/max_frequency_stack_checker.sv -----
// Checker for the maximum-frequency stack: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module max_frequency_stack_checker
    import mfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        fail_count,
    output int        pending_words,
    output int        pops_seen,
    output int        empties_seen,
    output int        fulls_seen
);

    value_t    key_val [DISTINCT_KEYS];
    int        key_cnt [DISTINCT_KEYS];
    value_t    held_val [CAPACITY];
    int        held_below [CAPACITY];
    int        head_of [CAPACITY];
    int        free_next [CAPACITY];
    int        free_first;
    int        top;
    out_word_t awaited_words [$];

    assign pending_words = awaited_words.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d, want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int key_of(input value_t v);
        for (int i = 0; i < DISTINCT_KEYS; i++)
            if (key_cnt[i] != 0 && key_val[i] == v) return i;
        return -1;
    endfunction

    function automatic out_word_t stack_step(input in_word_t w);
        out_word_t r;
        int k;
        int s;
        int lvl;
        r.popped_value = '0;
        r.status = STATUS_DONE;
        if (w.command == CMD_PUSH) begin
            k = key_of(w.value);
            if (k < 0)
                for (int i = DISTINCT_KEYS - 1; i >= 0; i--)
                    if (key_cnt[i] == 0) k = i;
            if (k < 0 || free_first >= CAPACITY) begin
                r.status = STATUS_FULL;
            end else begin
                s = free_first;
                free_first = free_next[s];
                key_val[k] = w.value;
                key_cnt[k]++;
                lvl = key_cnt[k];
                held_val[s] = w.value;
                held_below[s] = head_of[lvl-1];
                head_of[lvl-1] = s;
                if (lvl > top) top = lvl;
            end
        end else if (top == 0 || head_of[top-1] >= CAPACITY) begin
            r.status = STATUS_EMPTY;
        end else begin
            s = head_of[top-1];
            r.popped_value = held_val[s];
            head_of[top-1] = held_below[s];
            free_next[s] = free_first;
            free_first = s;
            k = key_of(held_val[s]);
            if (k >= 0) key_cnt[k]--;
            if (head_of[top-1] >= CAPACITY) top--;
        end
        r.top_level = 7'(top);
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        out_word_t step_out;
        if (!aresetn) begin
            for (int i = 0; i < DISTINCT_KEYS; i++) key_cnt[i] = 0;
            for (int i = 0; i < CAPACITY; i++) begin
                head_of[i] = CAPACITY;
                free_next[i] = i + 1;
            end
            free_first = 0;
            top = 0;
            awaited_words.delete();
            fail_count = 0;
            pops_seen = 0;
            empties_seen = 0;
            fulls_seen = 0;
        end else begin
            if (s_valid && s_ready) begin
                step_out = stack_step(s_data);
                if (s_data.command == CMD_POP && step_out.status == STATUS_DONE)
                    pops_seen++;
                awaited_words.push_back(step_out);
            end
            if (m_valid && m_ready) begin
                if (awaited_words.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    want = awaited_words.pop_front();
                    if (m_data.popped_value !== want.popped_value)
                        report("popped_value", m_data.popped_value, want.popped_value);
                    if (m_data.status !== want.status)
                        report("status", m_data.status, want.status);
                    if (m_data.top_level !== want.top_level)
                        report("top_level", m_data.top_level, want.top_level);
                    if (want.status == STATUS_EMPTY) empties_seen++;
                    else if (want.status == STATUS_FULL) fulls_seen++;
                end
            end
        end
    end

endmodule

// ----- bench/max_frequency_stack_unit_test.sv -----
// Testbench top for the maximum-frequency stack: stimulus, reset and verdict.
`timescale 1ns / 1ps
module max_frequency_stack_unit_test;
    import mfs_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    int        fail_count;
    int        pending_words;
    int        pops_seen;
    int        empties_seen;
    int        fulls_seen;
    int        words_sent = 0;
    bit        busy_phase = 1'b1;
    value_t    pool [8];

    always #4 aclk = ~aclk;

    max_frequency_stack_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    max_frequency_stack_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_words(pending_words),
        .pops_seen(pops_seen), .empties_seen(empties_seen), .fulls_seen(fulls_seen)
    );

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= busy_phase ? ($urandom_range(99) >= 33) : 1'b1;
    end

    task automatic send_word(input logic cmd, input value_t v);
        while (busy_phase && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{command: cmd, value: v};
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(3))
            0: return pool[$urandom_range(1)];
            1: return pool[$urandom_range(3)];
            2: return pool[$urandom_range(7)];
            default: return $urandom;
        endcase
    endfunction

    initial begin
        #2_000_000;
        $display("max_frequency_stack_unit_test: done, errors");
        $finish;
    end

    initial begin
        int guard;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: empty pop, extremes, ties, key table full, store full
        send_word(CMD_POP, 32'sd0);
        send_word(CMD_PUSH, 32'h8000_0000);
        send_word(CMD_PUSH, 32'h7fff_ffff);
        send_word(CMD_PUSH, 32'hffff_ffff);
        send_word(CMD_PUSH, 32'h8000_0000);
        send_word(CMD_PUSH, 32'h0);
        for (int i = 0; i < 13; i++) send_word(CMD_PUSH, 32'(i + 100));
        send_word(CMD_PUSH, 32'h5555_aaaa);
        repeat (19) send_word(CMD_POP, 32'hffff_ffff);
        for (int i = 0; i < 66; i++) send_word(CMD_PUSH, 32'(i % 3));
        repeat (67) send_word(CMD_POP, 32'sd0);
        s_valid <= 1'b0;
        guard = 0;
        while (pending_words != 0 && guard < 10000) begin
            @(posedge aclk);
            guard++;
        end
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < 8; i++) pool[i] = $urandom;
            busy_phase = (ph != 2);
            for (int i = 0; i < 370; i++) begin
                if ($urandom_range(99) < 55) send_word(CMD_PUSH, pick_value());
                else send_word(CMD_POP, $urandom);
            end
            if (ph == 1) begin
                s_valid <= 1'b0;
                guard = 0;
                while (pending_words != 0 && guard < 10000) begin
                    @(posedge aclk);
                    guard++;
                end
            end
        end
        s_valid <= 1'b0;
        busy_phase = 1'b0;
        guard = 0;
        while (pending_words != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        $display("sent %0d words; %0d pops, %0d empty pops, %0d dropped pushes answered",
                 words_sent, pops_seen, empties_seen, fulls_seen);
        $display("random mix of pushes and pops over small value pools, with stalls on both sides");
        if (fail_count == 0 && pending_words == 0)
            $display("max_frequency_stack_unit_test: done, clean");
        else
            $display("max_frequency_stack_unit_test: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mfs_pkg.sv
rtl/mfs_keys.sv
rtl/mfs_store.sv
rtl/max_frequency_stack_unit.sv
bench/max_frequency_stack_checker.sv
bench/max_frequency_stack_unit_test.sv
